>>> rtl/koq_pkg.sv
`default_nettype none
package koq_pkg;

    localparam int CMD_W    = 4;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;
    localparam int TALLY_W  = 7;

    localparam logic [CMD_W-1:0] CMD_PREPEND    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND     = 4'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_GET        = 4'd3;
    localparam logic [CMD_W-1:0] CMD_MOVE_FRONT = 4'd4;
    localparam logic [CMD_W-1:0] CMD_MOVE_BACK  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 4'd6;
    localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_COUNT      = 4'd8;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic load;
        logic pass_step;
        logic park_step;
        logic insert;
        logic finish;
    } t_ctl;

    typedef struct packed {
        logic len_zero;
        logic pass_last;
        logic need_park;
        logic park_last;
    } t_sts;

endpackage
`default_nettype wire

>>> rtl/koq_if.sv
`default_nettype none
interface koq_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd;
    logic [31:0] key;
    logic [31:0] value;

    modport source (output valid, output cmd, output key, output value, input ready);
    modport sink (input valid, input cmd, input key, input value, output ready);
endinterface

interface koq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] found_key;
    logic [31:0] found_value;
    logic [6:0]  tally;
    logic        is_empty;

    modport source (output valid, output status, output found_key, output found_value,
                    output tally, output is_empty, input ready);
    modport sink (input valid, input status, input found_key, input found_value,
                  input tally, input is_empty, output ready);
endinterface
`default_nettype wire

>>> rtl/koq_ctl.sv
`default_nettype none
module koq_ctl
    import koq_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PASS = 3'd1;
    localparam logic [2:0] S_POST = 3'd2;
    localparam logic [2:0] S_PARK = 3'd3;
    localparam logic [2:0] S_INS  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_accept, w_finish;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = o_in_ready && i_in_valid;
    assign w_finish    = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_ctl           = '0;
        o_ctl.load      = w_accept;
        o_ctl.pass_step = (r_state == S_PASS);
        o_ctl.park_step = (r_state == S_PARK);
        o_ctl.insert    = (r_state == S_INS);
        o_ctl.finish    = w_finish;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_sts.len_zero ? S_POST : S_PASS;
                end
            end
            S_PASS: begin
                if (i_sts.pass_last) begin
                    n_state = S_POST;
                end
            end
            S_POST: n_state = i_sts.need_park ? S_PARK : S_INS;
            S_PARK: begin
                if (i_sts.park_last) begin
                    n_state = S_INS;
                end
            end
            S_INS: n_state = S_FIN;
            S_FIN: begin
                if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

>>> rtl/koq_dp.sv
`default_nettype none
module koq_dp
    import koq_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_ctl                 i_ctl,
    output t_sts                 o_sts,
    input  wire  [CMD_W-1:0]     i_cmd,
    input  wire  [FIELD_W-1:0]   i_key,
    input  wire  [FIELD_W-1:0]   i_value,
    output logic [STATUS_W-1:0]  o_status,
    output logic [FIELD_W-1:0]   o_found_key,
    output logic [FIELD_W-1:0]   o_found_value,
    output logic [TALLY_W-1:0]   o_tally,
    output logic                 o_is_empty
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = $clog2(CAPACITY);

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_ROT   = 3'd1;
    localparam logic [2:0] OP_POP   = 3'd2;
    localparam logic [2:0] OP_PUSHB = 3'd3;
    localparam logic [2:0] OP_PUSHF = 3'd4;

    logic [KEY_BITS-1:0]   r_cell_key  [CAPACITY];
    logic [VALUE_BITS-1:0] r_cell_val  [CAPACITY];
    logic [RW-1:0]         r_cell_rank [CAPACITY];
    logic [VALUE_BITS-1:0] r_park      [CAPACITY];

    logic [CW-1:0]         r_len, n_len;
    logic [CW-1:0]         r_n0, r_step, r_cnt, r_pidx;
    logic [CMD_W-1:0]      r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_full, r_hit;
    logic [KEY_BITS-1:0]   r_fk;
    logic [VALUE_BITS-1:0] r_fv;

    logic [2:0]            w_op;
    logic [KEY_BITS-1:0]   w_key;
    logic [VALUE_BITS-1:0] w_val;
    logic [RW-1:0]         w_rank;
    logic                  w_match, w_move, w_park_wr;

    assign w_match = (r_cell_key[0] == r_key);
    assign w_move  = (r_cmd == CMD_MOVE_FRONT) || (r_cmd == CMD_MOVE_BACK);

    always_comb begin
        w_op      = OP_NONE;
        w_key     = r_cell_key[0];
        w_val     = r_cell_val[0];
        w_rank    = r_cell_rank[0];
        w_park_wr = 1'b0;
        if (i_ctl.pass_step) begin
            w_op = OP_ROT;
            case (r_cmd)
                CMD_PREPEND: begin
                    if (w_match && !r_full) begin
                        w_rank = r_cell_rank[0] + RW'(1);
                    end
                end
                CMD_DELETE: begin
                    if (w_match) begin
                        w_op = OP_POP;
                    end
                end
                CMD_MOVE_FRONT, CMD_MOVE_BACK: begin
                    if (w_match) begin
                        w_op      = OP_POP;
                        w_park_wr = 1'b1;
                    end
                end
                default: w_op = OP_ROT;
            endcase
        end else if (i_ctl.park_step) begin
            w_op   = (r_cmd == CMD_MOVE_FRONT) ? OP_PUSHF : OP_PUSHB;
            w_key  = r_key;
            w_val  = r_park[0];
            w_rank = RW'(r_pidx);
        end else if (i_ctl.insert && !r_full) begin
            w_key = r_key;
            w_val = r_val;
            case (r_cmd)
                CMD_PREPEND: begin
                    w_op   = OP_PUSHF;
                    w_rank = '0;
                end
                CMD_APPEND: begin
                    w_op   = OP_PUSHB;
                    w_rank = RW'(r_cnt);
                end
                default: w_op = OP_NONE;
            endcase
        end
    end

    always_comb begin
        n_len = r_len;
        case (w_op)
            OP_POP:   n_len = r_len - CW'(1);
            OP_PUSHB: n_len = r_len + CW'(1);
            OP_PUSHF: n_len = r_len + CW'(1);
            default:  n_len = r_len;
        endcase
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        always_ff @(posedge i_clk) begin
            case (w_op)
                OP_ROT: begin
                    if (r_len == CW'(gi + 1)) begin
                        r_cell_key[gi]  <= w_key;
                        r_cell_val[gi]  <= w_val;
                        r_cell_rank[gi] <= w_rank;
                    end else if (CW'(gi + 1) < r_len) begin
                        if (gi < CAPACITY - 1) begin
                            r_cell_key[gi]  <= r_cell_key[(gi + 1) % CAPACITY];
                            r_cell_val[gi]  <= r_cell_val[(gi + 1) % CAPACITY];
                            r_cell_rank[gi] <= r_cell_rank[(gi + 1) % CAPACITY];
                        end
                    end
                end
                OP_POP: begin
                    if (gi < CAPACITY - 1) begin
                        r_cell_key[gi]  <= r_cell_key[(gi + 1) % CAPACITY];
                        r_cell_val[gi]  <= r_cell_val[(gi + 1) % CAPACITY];
                        r_cell_rank[gi] <= r_cell_rank[(gi + 1) % CAPACITY];
                    end
                end
                OP_PUSHB: begin
                    if (r_len == CW'(gi)) begin
                        r_cell_key[gi]  <= w_key;
                        r_cell_val[gi]  <= w_val;
                        r_cell_rank[gi] <= w_rank;
                    end
                end
                OP_PUSHF: begin
                    if (gi == 0) begin
                        r_cell_key[gi]  <= w_key;
                        r_cell_val[gi]  <= w_val;
                        r_cell_rank[gi] <= w_rank;
                    end else begin
                        r_cell_key[gi]  <= r_cell_key[(gi + CAPACITY - 1) % CAPACITY];
                        r_cell_val[gi]  <= r_cell_val[(gi + CAPACITY - 1) % CAPACITY];
                        r_cell_rank[gi] <= r_cell_rank[(gi + CAPACITY - 1) % CAPACITY];
                    end
                end
                default: begin
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (w_park_wr && (r_cell_rank[0] == RW'(gi))) begin
                r_park[gi] <= r_cell_val[0];
            end else if (i_ctl.park_step && (gi < CAPACITY - 1)) begin
                r_park[gi] <= r_park[(gi + 1) % CAPACITY];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_cmd;
            r_key  <= KEY_BITS'(i_key);
            r_val  <= VALUE_BITS'(i_value);
            r_full <= (r_len == CW'(CAPACITY));
            r_n0   <= r_len;
            r_step <= '0;
            r_cnt  <= '0;
            r_pidx <= '0;
            r_hit  <= 1'b0;
            r_fk   <= '0;
            r_fv   <= '0;
        end else if (i_ctl.pass_step) begin
            r_step <= r_step + CW'(1);
            if (w_match && ((r_cmd == CMD_APPEND) || (r_cmd == CMD_DELETE) || w_move)) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if ((r_cmd == CMD_GET) && w_match && (r_cell_rank[0] == '0) && !r_hit) begin
                r_hit <= 1'b1;
                r_fv  <= r_cell_val[0];
            end
            if ((r_cmd == CMD_PEEK_BACK) || ((r_cmd == CMD_PEEK_FRONT) && (r_step == '0))) begin
                r_fk <= r_cell_key[0];
                r_fv <= r_cell_val[0];
            end
        end else if (i_ctl.park_step) begin
            r_pidx <= r_pidx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            o_found_key   <= FIELD_W'(r_fk);
            o_found_value <= FIELD_W'(r_fv);
            o_is_empty    <= (r_len == '0);
            case (r_cmd)
                CMD_PREPEND, CMD_APPEND: begin
                    o_status <= r_full ? ST_FULL : ST_OK;
                    o_tally  <= '0;
                end
                CMD_GET: begin
                    o_status <= r_hit ? ST_OK : ST_MISS;
                    o_tally  <= '0;
                end
                CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
                    o_status <= (r_n0 == '0) ? ST_MISS : ST_OK;
                    o_tally  <= '0;
                end
                CMD_DELETE, CMD_MOVE_FRONT, CMD_MOVE_BACK: begin
                    o_status <= ST_OK;
                    o_tally  <= TALLY_W'(r_cnt);
                end
                CMD_COUNT: begin
                    o_status <= ST_OK;
                    o_tally  <= TALLY_W'(r_len);
                end
                default: begin
                    o_status <= ST_OK;
                    o_tally  <= '0;
                end
            endcase
        end
    end

    assign o_sts.len_zero  = (r_len == '0);
    assign o_sts.pass_last = (r_step == (r_n0 - CW'(1)));
    assign o_sts.need_park = w_move && (r_cnt != '0);
    assign o_sts.park_last = (r_pidx == (r_cnt - CW'(1)));

endmodule
`default_nettype wire

>>> rtl/keyed_ordered_queue_unit.sv
// Each item runs through the pass, post, park, insert and finish states in that order before
// its result item is presented; pass is skipped when the store is empty, and park is used only
// by a move command that has matches. A new item is taken only once the last one is through;
// each item makes one pass over the entry ring, and a result that has not been taken holds the next one back.
// Reset is synchronous and active low: it empties the store and drops any
// pending result. Entry contents are not cleared.
`default_nettype none
module keyed_ordered_queue_unit
    import koq_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    koq_in_if.sink    i_in,
    koq_out_if.source o_out
);

    t_ctl w_ctl;
    t_sts w_sts;
    logic w_in_ready, w_out_valid;

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    koq_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    koq_dp #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .o_sts         (w_sts),
        .i_cmd         (i_in.cmd),
        .i_key         (i_in.key),
        .i_value       (i_in.value),
        .o_status      (o_out.status),
        .o_found_key   (o_out.found_key),
        .o_found_value (o_out.found_value),
        .o_tally       (o_out.tally),
        .o_is_empty    (o_out.is_empty)
    );

endmodule
`default_nettype wire

>>> rtl/koq_checker.sv
`default_nettype none
module koq_checker
    import koq_pkg::*;
(
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                i_in_ready,
    input wire                i_out_valid,
    input wire                i_out_ready,
    input wire [STATUS_W-1:0] i_status,
    input wire [FIELD_W-1:0]  i_found_key
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status))
        else $error("Result item dropped or changed while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Item accepted while the previous one is still in work.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK) || (i_status == ST_MISS) || (i_status == ST_FULL))
        else $error("Result item carries an unknown status.");

    a_key_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_found_key != '0) |-> (i_status == ST_OK))
        else $error("Key reported with a failing status.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result item shown straight after reset.");

endmodule

bind keyed_ordered_queue_unit koq_checker u_koq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_found_key (o_out.found_key)
);
`default_nettype wire

>>> tb/keyed_ordered_queue_unit_tb.sv
`timescale 1ns / 1ps
module keyed_ordered_queue_unit_tb;
    import koq_pkg::*;

    localparam int CAP = 64;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  found_key;
        logic [FIELD_W-1:0]  found_value;
        logic [TALLY_W-1:0]  tally;
        logic                is_empty;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    koq_in_if  in_ch ();
    koq_out_if out_ch ();

    keyed_ordered_queue_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_item  pending_items[$];
    t_reply expected_replies[$];
    int     error_count = 0;
    bit     hold_off = 0;
    bit     hold_off_request = 0;
    bit     stimulus_done = 0;

    logic [31:0] store_key[$];
    logic [31:0] store_value[$];
    int          store_rank[$];

    function automatic int gap_length();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic int matches_of(logic [31:0] k);
        int m;
        m = 0;
        foreach (store_key[i]) if (store_key[i] == k) m++;
        return m;
    endfunction

    function automatic t_reply apply_command(t_item it);
        t_reply r;
        int m, n, rk, other;
        logic [31:0] nk[$];
        logic [31:0] nv[$];
        int nr[$];
        r = '0;
        n = store_key.size();
        case (it.cmd)
            CMD_PREPEND, CMD_APPEND: begin
                if (n >= CAP) begin
                    r.status = ST_FULL;
                end else if (it.cmd == CMD_PREPEND) begin
                    foreach (store_key[i]) if (store_key[i] == it.key) store_rank[i]++;
                    store_key.push_front(it.key);
                    store_value.push_front(it.value);
                    store_rank.push_front(0);
                end else begin
                    m = matches_of(it.key);
                    store_key.push_back(it.key);
                    store_value.push_back(it.value);
                    store_rank.push_back(m);
                end
            end
            CMD_DELETE: begin
                for (int i = n - 1; i >= 0; i--) begin
                    if (store_key[i] == it.key) begin
                        store_key.delete(i);
                        store_value.delete(i);
                        store_rank.delete(i);
                        r.tally++;
                    end
                end
            end
            CMD_GET: begin
                r.status = ST_MISS;
                foreach (store_key[i]) begin
                    if (r.status == ST_MISS && store_key[i] == it.key && store_rank[i] == 0) begin
                        r.status = ST_OK;
                        r.found_value = store_value[i];
                    end
                end
            end
            CMD_MOVE_FRONT, CMD_MOVE_BACK: begin
                m = matches_of(it.key);
                r.tally = TALLY_W'(m);
                if (m > 0) begin
                    for (int i = 0; i < n; i++) begin
                        nk.push_back('0);
                        nv.push_back('0);
                        nr.push_back(0);
                    end
                    other = (it.cmd == CMD_MOVE_FRONT) ? m : 0;
                    for (int i = 0; i < n; i++) begin
                        if (store_key[i] == it.key) begin
                            rk = (store_rank[i] >= m) ? m - 1 : store_rank[i];
                            rk = (it.cmd == CMD_MOVE_FRONT) ? m - 1 - rk : n - m + rk;
                        end else begin
                            rk = other++;
                        end
                        nk[rk] = store_key[i];
                        nv[rk] = store_value[i];
                        nr[rk] = store_rank[i];
                    end
                    store_key = nk;
                    store_value = nv;
                    store_rank = nr;
                end
            end
            CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
                if (n == 0) begin
                    r.status = ST_MISS;
                end else begin
                    rk = (it.cmd == CMD_PEEK_FRONT) ? 0 : n - 1;
                    r.found_key = store_key[rk];
                    r.found_value = store_value[rk];
                end
            end
            CMD_COUNT: r.tally = TALLY_W'(n);
            default: ;
        endcase
        r.is_empty = (store_key.size() == 0);
        return r;
    endfunction

    function automatic t_item make_item(logic [3:0] c, logic [31:0] k, logic [31:0] v);
        t_item it;
        it.cmd = c;
        it.key = k;
        it.value = v;
        return it;
    endfunction

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
            default: return $urandom_range(0, 7);
        endcase
    endfunction

    int send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.cmd <= '0;
            in_ch.key <= '0;
            in_ch.value <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_replies.push_back(apply_command(
                    make_item(in_ch.cmd, in_ch.key, in_ch.value)));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    t_item it;
                    it = pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.cmd <= it.cmd;
                    in_ch.key <= it.key;
                    in_ch.value <= it.value;
                    send_gap <= gap_length();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        wait (hold_off_request);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    int recv_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                t_reply got, want;
                got.status = out_ch.status;
                got.found_key = out_ch.found_key;
                got.found_value = out_ch.found_value;
                got.tally = out_ch.tally;
                got.is_empty = out_ch.is_empty;
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    error_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected %p, actual %p", $time, want, got);
                        error_count++;
                    end
                end
            end
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) recv_gap <= gap_length();
            end
        end
    end

    initial begin
        logic [31:0] k;
        int r;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_items.push_back(make_item(CMD_PEEK_FRONT, 0, 0));
        pending_items.push_back(make_item(CMD_PEEK_BACK, 0, 0));
        pending_items.push_back(make_item(CMD_GET, 5, 0));
        pending_items.push_back(make_item(CMD_COUNT, 0, 0));
        pending_items.push_back(make_item(CMD_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_items.push_back(make_item(CMD_PREPEND, 0, 0));
        pending_items.push_back(make_item(CMD_APPEND, 1, 32'h1111));
        pending_items.push_back(make_item(CMD_PREPEND, 1, 32'h2222));
        pending_items.push_back(make_item(CMD_APPEND, 1, 32'h3333));
        pending_items.push_back(make_item(CMD_GET, 1, 0));
        pending_items.push_back(make_item(CMD_MOVE_FRONT, 1, 0));
        pending_items.push_back(make_item(CMD_PEEK_FRONT, 0, 0));
        pending_items.push_back(make_item(CMD_MOVE_BACK, 1, 0));
        pending_items.push_back(make_item(CMD_PEEK_BACK, 0, 0));
        pending_items.push_back(make_item(CMD_MOVE_BACK, 9, 0));
        pending_items.push_back(make_item(CMD_DELETE, 9, 0));
        pending_items.push_back(make_item(CMD_DELETE, 1, 0));
        pending_items.push_back(make_item(4'd9, 1, 1));
        pending_items.push_back(make_item(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_items.push_back(make_item(CMD_COUNT, 0, 0));

        // The store is filled beyond capacity, and partway through the fill the receiver stalls.
        for (int i = 0; i < 70; i++) begin
            pending_items.push_back(make_item(i[0] ? CMD_APPEND : CMD_PREPEND,
                $urandom_range(0, 3), $urandom()));
        end
        pending_items.push_back(make_item(CMD_COUNT, 0, 0));
        while (pending_items.size() > 60) @(posedge i_clk);
        hold_off_request = 1;
        pending_items.push_back(make_item(CMD_MOVE_FRONT, 2, 0));
        pending_items.push_back(make_item(CMD_MOVE_BACK, 3, 0));
        pending_items.push_back(make_item(CMD_GET, 2, 0));
        for (int i = 0; i < 4; i++) pending_items.push_back(make_item(CMD_DELETE, i, 0));

        for (int i = 0; i < 1100; i++) begin
            k = pick_key();
            r = $urandom_range(0, 99);
            if (r < 40)
                pending_items.push_back(make_item(4'($urandom_range(0, 1)), k, $urandom()));
            else if (r < 50)
                pending_items.push_back(make_item(CMD_DELETE, k, 0));
            else if (r < 97)
                pending_items.push_back(make_item(4'($urandom_range(3, 8)), k, $urandom()));
            else
                pending_items.push_back(make_item(4'($urandom_range(9, 15)), $urandom(),
                    $urandom()));
        end
        stimulus_done = 1;
    end

    initial begin
        wait (stimulus_done);
        while (pending_items.size() > 0 || in_ch.valid || expected_replies.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0)
            $display("keyed_ordered_queue_unit_tb: clean");
        else
            $display("keyed_ordered_queue_unit_tb: errors");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("keyed_ordered_queue_unit_tb: errors");
        $finish;
    end

endmodule
